### rtl/ptw_pkg.sv
`default_nettype none

package ptw_pkg;

  localparam int unsigned DirEntries   = 1024;
  localparam int unsigned TableEntries = 1024;
  localparam int unsigned DirIdxW      = $clog2(DirEntries);
  localparam int unsigned TblIdxW      = $clog2(TableEntries);
  localparam int unsigned ClrCntW      = (DirIdxW > TblIdxW) ? DirIdxW : TblIdxW;

  typedef enum logic [1:0] {
    CMD_TRANSLATE = 2'd0,
    CMD_WR_DIR    = 2'd1,
    CMD_WR_TBL    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_FAULT,
    RES_LARGE,
    RES_SMALL
  } res_sel_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_TBL,
    S_ACK
  } state_e;

  typedef struct packed {
    logic        present;
    logic        big_page;
    logic [19:0] base;
  } dir_entry_t;

  typedef struct packed {
    logic        present;
    logic [19:0] base;
  } tbl_entry_t;

  typedef struct packed {
    logic     clear_en;
    logic     accept;
    logic     tbl_rd;
    logic     out_load;
    res_sel_e res_sel;
  } ptw_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic dir_present;
    logic dir_large;
    logic dir_match;
    logic tbl_present;
  } ptw_sts_t;

endpackage

`default_nettype wire

### rtl/two_level_page_translation.sv
// Two-level page translation, 4 KiB and 4 MiB pages.
// Request channel: in_valid_i / in_stall_o carries a command with its fields;
// translate walks the directory and page table, the two write commands load
// one directory or table entry. Every request gives exactly one response on
// out_valid_o / out_stall_i: physical address and fault flag (zero for writes).
// Config channel: cfg_valid_i / cfg_ready_o loads the accepted table base;
// ready is always high, write only while no request is outstanding.
// A write or a translation that ends at the directory (large page or fault)
// is answered from the state after acceptance; a 4 KiB walk also reads the
// page table, both stores having registered read ports. The next request is
// taken in the cycle the response is loaded: one request a cycle for writes
// and large pages while the output is free; a 4 KiB walk first reads its table.
// After reset both stores are zeroed one entry per cycle, all 1024 entries;
// in_stall_o stays high meanwhile.
// A stalled response is held in the output register; a walk in progress then
// waits to load its result and no further request is taken until the output frees.
`default_nettype none

module two_level_page_translation
  import ptw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [19:0] cfg_walk_table_base_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] vaddr_i,
  input  wire logic [9:0]  entry_index_i,
  input  wire logic        entry_present_i,
  input  wire logic        entry_large_i,
  input  wire logic [19:0] entry_base_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      physical_addr_o,
  output logic             fault_o
);

  ptw_cmd_t cmd;
  ptw_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ptw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ptw_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_walk_table_base_i (cfg_walk_table_base_i),
    .command_i             (command_i),
    .vaddr_i               (vaddr_i),
    .entry_index_i         (entry_index_i),
    .entry_present_i       (entry_present_i),
    .entry_large_i         (entry_large_i),
    .entry_base_i          (entry_base_i),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .physical_addr_o       (physical_addr_o),
    .fault_o               (fault_o)
  );

endmodule

`default_nettype wire

### rtl/ptw_ctrl.sv
`default_nettype none

module ptw_ctrl
  import ptw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] command_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output ptw_cmd_t        cmd_o,
  input  wire ptw_sts_t   sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    logic finish;
    finish          = 1'b0;
    state_d         = state_q;
    in_stall_o      = 1'b1;
    cmd_o.clear_en  = 1'b0;
    cmd_o.accept    = 1'b0;
    cmd_o.tbl_rd    = 1'b0;
    cmd_o.out_load  = 1'b0;
    cmd_o.res_sel   = RES_NONE;

    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
      end
      S_DIR: begin
        if (!sts_i.dir_present) begin
          cmd_o.res_sel = RES_FAULT;
          finish        = 1'b1;
        end else if (sts_i.dir_large) begin
          cmd_o.res_sel = RES_LARGE;
          finish        = 1'b1;
        end else if (!sts_i.dir_match) begin
          cmd_o.res_sel = RES_FAULT;
          finish        = 1'b1;
        end else begin
          cmd_o.tbl_rd = 1'b1;
          state_d      = S_TBL;
        end
      end
      S_TBL: begin
        cmd_o.res_sel = sts_i.tbl_present ? RES_SMALL : RES_FAULT;
        finish        = 1'b1;
      end
      S_ACK: begin
        cmd_o.res_sel = RES_NONE;
        finish        = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (finish) begin
      if (out_free) begin
        cmd_o.out_load = 1'b1;
        in_stall_o     = 1'b0;
        state_d        = S_IDLE;
      end else begin
        state_d = state_q;
      end
    end

    if (!in_stall_o && in_valid_i) begin
      cmd_o.accept = 1'b1;
      state_d      = (command_i == CMD_TRANSLATE) ? S_DIR : S_ACK;
    end

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

endmodule

`default_nettype wire

### rtl/ptw_dp.sv
`default_nettype none

module ptw_dp
  import ptw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [19:0] cfg_walk_table_base_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] vaddr_i,
  input  wire logic [9:0]  entry_index_i,
  input  wire logic        entry_present_i,
  input  wire logic        entry_large_i,
  input  wire logic [19:0] entry_base_i,
  input  wire ptw_cmd_t    cmd_i,
  output ptw_sts_t         sts_o,
  output logic [31:0]      physical_addr_o,
  output logic             fault_o
);

  dir_entry_t dir_mem [DirEntries];
  tbl_entry_t tbl_mem [TableEntries];

  logic [19:0]        table_base_q;
  logic [ClrCntW-1:0] clr_cnt_q;
  logic [31:0]        va_q;
  dir_entry_t         dir_rd_q;
  tbl_entry_t         tbl_rd_q;
  logic [31:0]        pa_q, pa_d;
  logic               fault_q, fault_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_base_q <= '0;
      clr_cnt_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        table_base_q <= cfg_walk_table_base_i;
      end
      if (cmd_i.clear_en) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // directory store
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en) begin
      dir_mem[clr_cnt_q[DirIdxW-1:0]] <= '0;
    end else if (cmd_i.accept && command_i == CMD_WR_DIR) begin
      dir_mem[entry_index_i] <= '{present: entry_present_i, big_page: entry_large_i,
                                  base: entry_base_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dir_rd_q <= dir_mem[vaddr_i[31:22]];
    end
  end

  // page table store
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en) begin
      tbl_mem[clr_cnt_q[TblIdxW-1:0]] <= '0;
    end else if (cmd_i.accept && command_i == CMD_WR_TBL) begin
      tbl_mem[entry_index_i] <= '{present: entry_present_i, base: entry_base_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_rd) begin
      tbl_rd_q <= tbl_mem[va_q[21:12]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      va_q <= vaddr_i;
    end
    if (cmd_i.out_load) begin
      pa_q    <= pa_d;
      fault_q <= fault_d;
    end
  end

  always_comb begin
    pa_d    = '0;
    fault_d = 1'b0;
    case (cmd_i.res_sel)
      RES_FAULT: fault_d = 1'b1;
      RES_LARGE: pa_d    = {dir_rd_q.base[9:0], va_q[21:0]};
      RES_SMALL: pa_d    = {tbl_rd_q.base, va_q[11:0]};
      default:   pa_d    = '0;
    endcase
  end

  assign sts_o.clear_last  = &clr_cnt_q;
  assign sts_o.dir_present = dir_rd_q.present;
  assign sts_o.dir_large   = dir_rd_q.big_page;
  assign sts_o.dir_match   = (dir_rd_q.base == table_base_q);
  assign sts_o.tbl_present = tbl_rd_q.present;

  assign physical_addr_o = pa_q;
  assign fault_o         = fault_q;

endmodule

`default_nettype wire

### sim/translation_checker.sv
`default_nettype none

module translation_checker
  import ptw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [19:0] cfg_walk_table_base_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] vaddr_i,
  input  wire logic [9:0]  entry_index_i,
  input  wire logic        entry_present_i,
  input  wire logic        entry_large_i,
  input  wire logic [19:0] entry_base_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [31:0] physical_addr_i,
  input  wire logic        fault_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        present;
    logic        big_page;
    logic [19:0] base;
  } dir_slot_t;

  typedef struct packed {
    logic        present;
    logic [19:0] frame;
  } tbl_slot_t;

  typedef struct packed {
    logic [31:0] phys;
    logic        fault;
  } xlat_t;

  dir_slot_t dir_mem [DirEntries];
  tbl_slot_t tbl_mem [TableEntries];
  logic [19:0] walk_base;
  xlat_t expected_xlat_q [$];

  task automatic predict_translation(input logic [1:0] cmd, input logic [31:0] va,
                                     input logic [9:0] idx, input logic pres,
                                     input logic big, input logic [19:0] base,
                                     output xlat_t res);
    dir_slot_t d;
    tbl_slot_t t;
    res = '0;
    case (cmd)
      CMD_TRANSLATE: begin
        d = dir_mem[va[31:22]];
        t = tbl_mem[va[21:12]];
        res.fault = 1'b1;
        if (d.present && d.big_page) begin
          res.phys  = {d.base[9:0], va[21:0]};
          res.fault = 1'b0;
        end else if (d.present && d.base == walk_base && t.present) begin
          res.phys  = {t.frame, va[11:0]};
          res.fault = 1'b0;
        end
      end
      CMD_WR_DIR: dir_mem[idx] = '{present: pres, big_page: big, base: base};
      CMD_WR_TBL: tbl_mem[idx] = '{present: pres, frame: base};
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    xlat_t res;
    xlat_t exp_res;
    if (!rst_ni) begin
      for (int i = 0; i < DirEntries; i++) dir_mem[i] = '0;
      for (int i = 0; i < TableEntries; i++) tbl_mem[i] = '0;
      walk_base = '0;
      expected_xlat_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) walk_base = cfg_walk_table_base_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_xlat_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got addr %h fault %b",
                   $time, physical_addr_i, fault_i);
          fail_count_o++;
        end else begin
          exp_res = expected_xlat_q.pop_front();
          if (physical_addr_i !== exp_res.phys) begin
            $display("%0t: physical_addr expected %h got %h",
                     $time, exp_res.phys, physical_addr_i);
            fail_count_o++;
          end
          if (fault_i !== exp_res.fault) begin
            $display("%0t: fault expected %b got %b", $time, exp_res.fault, fault_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_translation(command_i, vaddr_i, entry_index_i, entry_present_i,
                            entry_large_i, entry_base_i, res);
        expected_xlat_q.push_back(res);
      end
      pending_o = expected_xlat_q.size();
    end
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top
  import ptw_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CmdUnused  = 2'd3;
  localparam int         CycleLimit = 200000;
  localparam int         PhaseItems = 275;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [19:0] cfg_base = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_TRANSLATE;
  logic [31:0] vaddr = '0;
  logic [9:0]  entry_index = '0;
  logic        entry_present = 1'b0;
  logic        entry_large = 1'b0;
  logic [19:0] entry_base = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] physical_addr;
  logic        fault;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [19:0] cur_base = '0;
  logic [9:0]  hot_dir [8];
  logic [9:0]  hot_tbl [8];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  two_level_page_translation dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_walk_table_base_i (cfg_base),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .command_i             (command),
    .vaddr_i               (vaddr),
    .entry_index_i         (entry_index),
    .entry_present_i       (entry_present),
    .entry_large_i         (entry_large),
    .entry_base_i          (entry_base),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .physical_addr_o       (physical_addr),
    .fault_o               (fault)
  );

  translation_checker u_checker (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_i           (cfg_ready),
    .cfg_walk_table_base_i (cfg_base),
    .in_valid_i            (in_valid),
    .in_stall_i            (in_stall),
    .command_i             (command),
    .vaddr_i               (vaddr),
    .entry_index_i         (entry_index),
    .entry_present_i       (entry_present),
    .entry_large_i         (entry_large),
    .entry_base_i          (entry_base),
    .out_valid_i           (out_valid),
    .out_stall_i           (out_stall),
    .physical_addr_i       (physical_addr),
    .fault_i               (fault),
    .fail_count_o          (fail_count),
    .pending_o             (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // entered and left at a falling edge
  task automatic issue_request(input logic [1:0] cmd, input logic [31:0] va,
                               input logic [9:0] idx, input logic pres,
                               input logic big, input logic [19:0] base);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    command       <= cmd;
    vaddr         <= va;
    entry_index   <= idx;
    entry_present <= pres;
    entry_large   <= big;
    entry_base    <= base;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_table_base(input logic [19:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cur_base  = value;
    cfg_base  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [9:0] pick_slot(input bit table_side);
    if ($urandom_range(99) >= 80) return 10'($urandom_range(1023));
    return table_side ? hot_tbl[$urandom_range(7)] : hot_dir[$urandom_range(7)];
  endfunction

  // mostly translations; directory writes mostly name the accepted table
  task automatic random_request();
    int pick;
    logic [19:0] base;
    pick = $urandom_range(99);
    base = 20'($urandom);
    if (pick < 22) begin
      if ($urandom_range(99) < 65) base = cur_base;
      issue_request(CMD_WR_DIR, $urandom, pick_slot(1'b0), $urandom_range(99) < 85,
                    $urandom_range(99) < 30, base);
    end else if (pick < 44) begin
      issue_request(CMD_WR_TBL, $urandom, pick_slot(1'b1), $urandom_range(99) < 85,
                    1'($urandom), base);
    end else if (pick < 95) begin
      issue_request(CMD_TRANSLATE, {pick_slot(1'b0), pick_slot(1'b1), 12'($urandom)},
                    10'($urandom), 1'($urandom), 1'($urandom), base);
    end else begin
      issue_request(CmdUnused, $urandom, 10'($urandom), 1'($urandom), 1'($urandom), base);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_table_base(20'hFFFFF);
    issue_request(CMD_TRANSLATE, 32'h0000_0000, '0, 1'b0, 1'b0, '0);
    issue_request(CMD_TRANSLATE, 32'hFFFF_FFFF, '1, 1'b1, 1'b1, '1);
    issue_request(CMD_WR_DIR, '0, 10'd0, 1'b1, 1'b1, 20'hFFFFF);
    issue_request(CMD_TRANSLATE, 32'h003F_FFFF, '0, 1'b0, 1'b0, '0);
    issue_request(CMD_WR_DIR, '0, 10'd1023, 1'b1, 1'b0, 20'hFFFFF);
    // table entry still absent
    issue_request(CMD_TRANSLATE, 32'hFFC0_5ABC, '0, 1'b0, 1'b0, '0);
    // large flag on a table write is ignored
    issue_request(CMD_WR_TBL, '0, 10'd5, 1'b1, 1'b1, 20'hFFFFF);
    issue_request(CMD_TRANSLATE, 32'hFFC0_5ABC, '0, 1'b0, 1'b0, '0);
    issue_request(CMD_WR_TBL, '1, 10'd1023, 1'b1, 1'b0, 20'h00000);
    issue_request(CMD_TRANSLATE, 32'hFFFF_F123, '0, 1'b0, 1'b0, '0);
    // table base mismatch
    issue_request(CMD_WR_DIR, '0, 10'd2, 1'b1, 1'b0, 20'h12345);
    issue_request(CMD_TRANSLATE, 32'h0080_5000, '0, 1'b0, 1'b0, '0);
    // absent large entry
    issue_request(CMD_WR_DIR, '0, 10'd3, 1'b0, 1'b1, 20'h003FF);
    issue_request(CMD_TRANSLATE, 32'h00C0_0000, '0, 1'b0, 1'b0, '0);
    // unused command must leave table slot 5 alone
    issue_request(CmdUnused, '1, 10'd5, 1'b0, 1'b1, '1);
    issue_request(CMD_TRANSLATE, 32'hFFC0_5000, '0, 1'b0, 1'b0, '0);
    issue_request(CMD_WR_TBL, '0, 10'd0, 1'b0, 1'b0, '1);
    issue_request(CMD_TRANSLATE, 32'hFFC0_0FFF, '0, 1'b0, 1'b0, '0);
    issue_request(CMD_WR_DIR, '1, 10'd0, 1'b0, 1'b0, '0);
    issue_request(CMD_TRANSLATE, 32'h0000_0FFF, '0, 1'b0, 1'b0, '0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_table_base(20'h00000); end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  write_table_base(20'($urandom)); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; write_table_base(20'hFFFFF); end
        default: begin
          send_idle_pct = 31; recv_stall_pct = 31; write_table_base(20'($urandom));
        end
      endcase
      hot_dir[0] = 10'd0;
      hot_tbl[0] = 10'd0;
      hot_dir[7] = 10'd1023;
      hot_tbl[7] = 10'd1023;
      for (int i = 1; i < 7; i++) begin
        hot_dir[i] = 10'($urandom);
        hot_tbl[i] = 10'($urandom);
      end
      repeat (PhaseItems) random_request();
    end

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
